// ----- rtl/fnms_pkg.sv -----
// ----------------------------------------------------------------------------
// Fuzzy name match scorer package
// Word types, register map and scoring constants shared by the scorer files.
// ----------------------------------------------------------------------------
package fnms_pkg;

    localparam int QUERY_CHARS_DEF = 32;
    localparam int QUERY_CHARS_MAX = 32;

    localparam int CHAR_W      = 8;
    localparam int SCORE_W     = 9;
    localparam int QLEN_W      = 6;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int QUERY_REGS  = 4;
    localparam int BYTES_PER_REG = CFG_DATA_W / CHAR_W;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN = 3'd4;

    localparam logic [SCORE_W-1:0] MATCH_POINTS = 9'd10;
    localparam logic [SCORE_W-1:0] RUN_BONUS    = 9'd5;
    localparam logic [SCORE_W-1:0] PREFIX_BONUS = 9'd20;

    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] SEPARATOR   = 8'h2F;

    typedef struct packed {
        logic [CHAR_W-1:0] path_char;
        logic              last_char;
    } path_word_t;

    typedef struct packed {
        logic [SCORE_W-1:0] name_score;
        logic               is_match;
    } score_word_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ----- rtl/fnms_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Fuzzy name match scorer configuration registers
// APB-style register file holding the query bytes and the query length.
// ----------------------------------------------------------------------------
module fnms_cfg_regs #(
    parameter int QUERY_CHARS = fnms_pkg::QUERY_CHARS_DEF,
    parameter int POS_W       = $clog2(QUERY_CHARS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fnms_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fnms_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fnms_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [fnms_pkg::CHAR_W-1:0]         query_bytes [QUERY_CHARS],
    output logic [POS_W-1:0]                    active_length
);
    import fnms_pkg::*;

    localparam int FLAT_W = QUERY_REGS * CFG_DATA_W;

    logic [CHAR_W-1:0]    qbyte_reg [QUERY_CHARS];
    logic [QLEN_W-1:0]    qlen_reg;
    logic [POS_W-1:0]     act_len_reg;
    logic [POS_W-1:0]     act_len_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [FLAT_W-1:0]    query_flat;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        if (pwdata[QLEN_W-1:0] > QLEN_W'(QUERY_CHARS))
        begin
            act_len_next = POS_W'(QUERY_CHARS);
        end
        else
        begin
            act_len_next = POS_W'(pwdata[QLEN_W-1:0]);
        end
    end

    genvar k;
    generate
        for (k = 0; k < QUERY_CHARS; k++)
        begin : g_qbyte
            localparam logic [CFG_IDX_W-1:0] OWNER = CFG_IDX_W'(k / BYTES_PER_REG);
            localparam int LSB = CHAR_W * (k % BYTES_PER_REG);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    qbyte_reg[k] <= '0;
                end
                else if (wr_en && reg_idx == OWNER)
                begin
                    qbyte_reg[k] <= pwdata[LSB +: CHAR_W];
                end
            end

            assign query_flat[CHAR_W*k +: CHAR_W] = qbyte_reg[k];
            assign query_bytes[k] = qbyte_reg[k];
        end
        if (QUERY_CHARS * CHAR_W < FLAT_W)
        begin : g_pad
            assign query_flat[FLAT_W-1:QUERY_CHARS*CHAR_W] = '0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg    <= '0;
            act_len_reg <= '0;
        end
        else if (wr_en && reg_idx == REG_QUERY_LEN)
        begin
            qlen_reg    <= pwdata[QLEN_W-1:0];
            act_len_reg <= act_len_next;
        end
    end

    assign active_length = act_len_reg;

    always_comb
    begin
        case (reg_idx)
            REG_QUERY_0:   prdata = query_flat[0*CFG_DATA_W +: CFG_DATA_W];
            REG_QUERY_1:   prdata = query_flat[1*CFG_DATA_W +: CFG_DATA_W];
            REG_QUERY_2:   prdata = query_flat[2*CFG_DATA_W +: CFG_DATA_W];
            REG_QUERY_3:   prdata = query_flat[3*CFG_DATA_W +: CFG_DATA_W];
            REG_QUERY_LEN: prdata = CFG_DATA_W'(qlen_reg);
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- rtl/fnms_score_core.sv -----
// ----------------------------------------------------------------------------
// Fuzzy name match scorer core
// Per-character match state and the score of the final path component.
// ----------------------------------------------------------------------------
module fnms_score_core #(
    parameter int QUERY_CHARS = fnms_pkg::QUERY_CHARS_DEF,
    parameter int POS_W       = $clog2(QUERY_CHARS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  fnms_pkg::path_word_t          path_in,
    input  logic [fnms_pkg::CHAR_W-1:0]   query_bytes [QUERY_CHARS],
    input  logic [POS_W-1:0]              active_length,
    output fnms_pkg::score_word_t         result
);
    import fnms_pkg::*;

    localparam int IDX_W = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1;

    logic [POS_W-1:0]   qpos_reg,     qpos_next,     qpos_upd;
    logic               lwm_reg,      lwm_next,      lwm_upd;
    logic [SCORE_W-1:0] score_reg,    score_next,    score_upd;
    logic [POS_W-1:0]   ppos_reg,     ppos_next,     ppos_upd;
    logic               intact_reg,   intact_next,   intact_upd;
    logic               nonempty_reg, nonempty_next, nonempty_upd;

    logic [CHAR_W-1:0]  q_byte;
    logic               hit;
    logic               full;
    logic               bonus;
    logic [SCORE_W-1:0] score_out;

    // While the prefix still holds, both positions advance together, so a
    // single query byte serves both the fuzzy and the exact comparison.
    assign q_byte = query_bytes[qpos_reg[IDX_W-1:0]];
    assign hit    = (qpos_reg < active_length) &&
                    (fold_case(path_in.path_char) == fold_case(q_byte));

    always_comb
    begin
        qpos_upd     = qpos_reg;
        lwm_upd      = lwm_reg;
        score_upd    = score_reg;
        ppos_upd     = ppos_reg;
        intact_upd   = intact_reg;
        nonempty_upd = nonempty_reg;
        if (path_in.path_char == SEPARATOR)
        begin
            qpos_upd     = '0;
            lwm_upd      = 1'b0;
            score_upd    = '0;
            ppos_upd     = '0;
            intact_upd   = 1'b1;
            nonempty_upd = 1'b0;
        end
        else
        begin
            nonempty_upd = 1'b1;
            if (hit)
            begin
                score_upd = score_reg + MATCH_POINTS + (lwm_reg ? RUN_BONUS : '0);
                lwm_upd   = 1'b1;
                qpos_upd  = qpos_reg + 1'b1;
            end
            else
            begin
                lwm_upd = 1'b0;
            end
            if (ppos_reg < active_length)
            begin
                if (path_in.path_char != q_byte)
                begin
                    intact_upd = 1'b0;
                end
                ppos_upd = ppos_reg + 1'b1;
            end
        end
    end

    assign full  = qpos_upd >= active_length;
    assign bonus = intact_upd && (ppos_upd >= active_length);

    always_comb
    begin
        score_out = '0;
        if (full)
        begin
            score_out = score_upd + (bonus ? PREFIX_BONUS : '0);
        end
    end

    assign result.name_score = score_out;
    assign result.is_match   = (score_out != '0) && nonempty_upd;

    always_comb
    begin
        qpos_next     = qpos_reg;
        lwm_next      = lwm_reg;
        score_next    = score_reg;
        ppos_next     = ppos_reg;
        intact_next   = intact_reg;
        nonempty_next = nonempty_reg;
        if (step)
        begin
            if (path_in.last_char)
            begin
                qpos_next     = '0;
                lwm_next      = 1'b0;
                score_next    = '0;
                ppos_next     = '0;
                intact_next   = 1'b1;
                nonempty_next = 1'b0;
            end
            else
            begin
                qpos_next     = qpos_upd;
                lwm_next      = lwm_upd;
                score_next    = score_upd;
                ppos_next     = ppos_upd;
                intact_next   = intact_upd;
                nonempty_next = nonempty_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg     <= '0;
            lwm_reg      <= 1'b0;
            score_reg    <= '0;
            ppos_reg     <= '0;
            intact_reg   <= 1'b1;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            qpos_reg     <= qpos_next;
            lwm_reg      <= lwm_next;
            score_reg    <= score_next;
            ppos_reg     <= ppos_next;
            intact_reg   <= intact_next;
            nonempty_reg <= nonempty_next;
        end
    end

    a_prefix_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        intact_reg |-> qpos_reg == ppos_reg)
        else $error("Prefix position has drifted from the query position.");

    a_run_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        lwm_reg |-> qpos_reg != '0)
        else $error("Run flag set with no query character consumed.");

    a_score_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        score_reg != '0 |-> qpos_reg != '0 && nonempty_reg)
        else $error("Score accumulated without a matched character.");

endmodule

// ----- rtl/fuzzy_name_match_scorer.sv -----
// ----------------------------------------------------------------------------
// Fuzzy name match scorer
// Scores the final component of a path against a configured query.
// ----------------------------------------------------------------------------
// The path arrives one character per word on the path channel (path_valid,
// path_stall, path_word); the word carrying last_char set closes the path.
// For each such word one score word leaves on the score channel (score_valid,
// score_stall, score_word); other words produce nothing.
// The user must write the query bytes and length through the APB-style port
// only while the block is idle; it is not enforced. pready is always high.
// An accepted word is held in the input register until it is consumed, and a
// last character's score is loaded into the output register as it is consumed;
// a stalled score word can hold a last character in the input register.
// One character is taken every cycle while path_stall is low; the rate is set
// by the single compare and add on the match state between the two registers.
// If the score word is stalled, characters that produce no score keep
// flowing; a further last character waits in the input register and
// path_stall is raised until the score word is taken.
// Reset clears the configuration to an empty query and clears both
// channels' valid flags and the match state.
// ----------------------------------------------------------------------------
module fuzzy_name_match_scorer #(
    parameter int QUERY_CHARS = fnms_pkg::QUERY_CHARS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fnms_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fnms_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fnms_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                path_valid,
    output logic                                path_stall,
    input  fnms_pkg::path_word_t                path_word,
    output logic                                score_valid,
    input  logic                                score_stall,
    output fnms_pkg::score_word_t               score_word
);
    import fnms_pkg::*;

    localparam int POS_W = $clog2(QUERY_CHARS + 1);

    logic              in_valid_reg, in_valid_next;
    path_word_t        in_word_reg;
    logic              out_valid_reg, out_valid_next;
    score_word_t       out_word_reg;
    logic              consume;
    logic              load_out;
    score_word_t       core_result;
    logic [CHAR_W-1:0] query_bytes [QUERY_CHARS];
    logic [POS_W-1:0]  active_length;

    fnms_cfg_regs #(
        .QUERY_CHARS (QUERY_CHARS),
        .POS_W       (POS_W)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .query_bytes   (query_bytes),
        .active_length (active_length)
    );

    fnms_score_core #(
        .QUERY_CHARS (QUERY_CHARS),
        .POS_W       (POS_W)
    ) u_score_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (consume),
        .path_in       (in_word_reg),
        .query_bytes   (query_bytes),
        .active_length (active_length),
        .result        (core_result)
    );

    assign consume = in_valid_reg &&
                     (!in_word_reg.last_char || !out_valid_reg || !score_stall);
    assign load_out   = consume && in_word_reg.last_char;
    assign path_stall = in_valid_reg && !consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!path_stall)
        begin
            in_valid_next = path_valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!score_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_valid && !path_stall)
        begin
            in_word_reg <= path_word;
        end
        if (load_out)
        begin
            out_word_reg <= core_result;
        end
    end

    assign score_valid = out_valid_reg;
    assign score_word  = out_word_reg;

    a_score_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(score_valid) |-> $past(in_valid_reg && in_word_reg.last_char))
        else $error("Score word raised without a closing character.");

    a_match_has_score: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid && score_word.is_match |-> score_word.name_score != '0)
        else $error("Match flag set on a zero score.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        path_stall |-> in_word_reg.last_char && score_valid && score_stall)
        else $error("Path stalled without a blocked score word.");

endmodule
